@@ rtl/asfr_pkg.sv @@
// Shared types and constants of the serial frame receiver.
`default_nettype none
package asfr_pkg;

	localparam int DEFAULT_MAX_DATA = 9;

	localparam logic [7:0] SYNC_RESET = 8'hA4;
	localparam logic [3:0] MAX_LENGTH_RESET = 4'd9;

	localparam logic [7:0] CHANNEL_MASK = 8'h07;
	localparam logic [2:0] CHANNEL_LIMIT = 3'd4;

	// configuration register indexes
	localparam logic REG_SYNC_VALUE = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_SYNC,
		ST_LEN,
		ST_ID,
		ST_DATA,
		ST_CHECK,
		ST_DRAIN
	} phase_t;

	typedef struct packed {
		logic seed;
		logic load_len;
		logic load_id;
		logic load_data;
		logic drain_start;
		logic drain_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sync_hit;
		logic len_ok;
		logic data_done;
		logic check_ok;
		logic drain_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

@@ rtl/asfr_ctrl.sv @@
// Frame parsing state machine of the serial frame receiver.
`default_nettype none
module asfr_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  asfr_pkg::dp_status_t  status,
	output asfr_pkg::ctrl_cmd_t   cmd
);

	asfr_pkg::phase_t state_q, state_d;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asfr_pkg::ST_SYNC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q == asfr_pkg::ST_DRAIN);
		accept   = in_valid && !in_stall;
		case (state_q)
			asfr_pkg::ST_SYNC: begin
				if (accept && status.sync_hit) begin
					cmd.seed = 1'b1;
					state_d  = asfr_pkg::ST_LEN;
				end
			end
			asfr_pkg::ST_LEN: begin
				if (accept) begin
					if (status.len_ok) begin
						cmd.load_len = 1'b1;
						state_d      = asfr_pkg::ST_ID;
					end else begin
						state_d = asfr_pkg::ST_SYNC;
					end
				end
			end
			asfr_pkg::ST_ID: begin
				if (accept) begin
					cmd.load_id = 1'b1;
					state_d     = asfr_pkg::ST_DATA;
				end
			end
			asfr_pkg::ST_DATA: begin
				if (accept) begin
					cmd.load_data = 1'b1;
					if (status.data_done) begin
						state_d = asfr_pkg::ST_CHECK;
					end
				end
			end
			asfr_pkg::ST_CHECK: begin
				if (accept) begin
					// the checksum byte is never taken as a sync byte
					if (status.check_ok) begin
						cmd.drain_start = 1'b1;
						state_d         = asfr_pkg::ST_DRAIN;
					end else begin
						state_d = asfr_pkg::ST_SYNC;
					end
				end
			end
			asfr_pkg::ST_DRAIN: begin
				if (status.out_free) begin
					cmd.drain_step = 1'b1;
					if (status.drain_last) begin
						state_d = asfr_pkg::ST_SYNC;
					end
				end
			end
			default: begin
				state_d = asfr_pkg::ST_SYNC;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/asfr_datapath.sv @@
// Registers, data buffer, checksum and result register of the serial frame receiver.
`default_nettype none
module asfr_datapath #(
	parameter int MAX_DATA = asfr_pkg::DEFAULT_MAX_DATA
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire  [7:0]            cfg_data,
	input  wire  [7:0]            rx_byte,
	input  asfr_pkg::ctrl_cmd_t   cmd,
	output asfr_pkg::dp_status_t  status,
	input  wire                   out_stall,
	output logic                  out_valid,
	output logic [7:0]            message_id,
	output logic [3:0]            frame_length,
	output logic [3:0]            byte_index,
	output logic [7:0]            data_byte,
	output logic [2:0]            channel_number,
	output logic                  channel_in_range,
	output logic                  last
);

	localparam int IdxW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam logic [7:0] MaxData8 = 8'(MAX_DATA);

	logic [7:0] sync_q;
	logic [3:0] max_len_q;
	logic [3:0] expected_q;
	logic [3:0] received_q;
	logic [7:0] check_q;
	logic [7:0] id_q;
	logic [2:0] chan_q;
	logic [3:0] k_q;
	logic [7:0] store_q [MAX_DATA];

	logic [7:0] max_len_ext;
	logic [7:0] limit;
	logic [4:0] received_inc;
	logic [4:0] k_inc;
	logic       store_en;

	assign max_len_ext  = {4'd0, max_len_q};
	assign limit        = (max_len_ext > MaxData8) ? MaxData8 : max_len_ext;
	assign received_inc = {1'b0, received_q} + 5'd1;
	assign k_inc        = {1'b0, k_q} + 5'd1;
	assign store_en     = cmd.load_data && (32'(received_q) < MAX_DATA);

	assign status.sync_hit   = (rx_byte == sync_q);
	assign status.len_ok     = (rx_byte != 8'd0) && (rx_byte <= limit);
	assign status.data_done  = (received_inc >= {1'b0, expected_q});
	assign status.check_ok   = (rx_byte == check_q);
	assign status.drain_last = (k_inc == {1'b0, expected_q});
	assign status.out_free   = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= asfr_pkg::SYNC_RESET;
			max_len_q <= asfr_pkg::MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				asfr_pkg::REG_SYNC_VALUE: sync_q    <= cfg_data;
				asfr_pkg::REG_MAX_LENGTH: max_len_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			received_q <= '0;
			check_q    <= asfr_pkg::SYNC_RESET;
			id_q       <= '0;
			k_q        <= '0;
		end else begin
			if (cmd.seed) begin
				check_q <= sync_q;
			end
			if (cmd.load_len) begin
				// len_ok bounds the length to at most 15
				expected_q <= rx_byte[3:0];
				received_q <= '0;
				check_q    <= check_q ^ rx_byte;
			end
			if (cmd.load_id) begin
				id_q    <= rx_byte;
				check_q <= check_q ^ rx_byte;
			end
			if (cmd.load_data) begin
				received_q <= received_inc[3:0];
				check_q    <= check_q ^ rx_byte;
			end
			if (cmd.drain_start) begin
				k_q <= '0;
			end else if (cmd.drain_step) begin
				k_q <= k_inc[3:0];
			end
		end
	end

	// buffer and channel capture, no reset needed
	always_ff @(posedge clk) begin
		if (store_en) begin
			store_q[IdxW'(received_q)] <= rx_byte;
		end
		if (cmd.load_data && received_q == 4'd0) begin
			chan_q <= 3'(rx_byte & asfr_pkg::CHANNEL_MASK);
		end
	end

	// result register: one entry of the buffer per drain step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.drain_step) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_step) begin
			message_id       <= id_q;
			frame_length     <= expected_q;
			byte_index       <= k_q;
			data_byte        <= store_q[IdxW'(k_q)];
			channel_number   <= chan_q;
			channel_in_range <= (chan_q < asfr_pkg::CHANNEL_LIMIT);
			last             <= status.drain_last;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ant_serial_frame_receiver.sv @@
// Serial frame receiver: finds sync/length/ID/data/checksum frames in a byte stream.
//
// Input channel: one received byte per transfer (in_valid, in_stall, rx_byte).
// The block takes a byte every cycle while it parses a frame: sync, length,
// message ID, data bytes, checksum (XOR seeded with the sync register).
// Bad lengths and checksum mismatches drop the frame silently.
// On a good checksum the block emits one result per data byte through a
// single output register (out_valid, out_stall). The parser enters its drain
// state after the checksum byte, then the first result is registered; the
// rest follow one per cycle while out_stall is low, and a stalled receiver
// holds the result and the drain. While results drain, in_stall is high;
// a frame of n data bytes is made of n + 4 input bytes.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 sync value, index 1
// maximum data length; writes take effect at once and are meant for idle.
// Reset clears the parser to waiting for sync and restores sync value 0xA4
// and maximum length 9; buffer contents are left as they are.
`default_nettype none
module ant_serial_frame_receiver #(
	parameter int MAX_DATA = asfr_pkg::DEFAULT_MAX_DATA
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire  [7:0] cfg_data,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] message_id,
	output logic [3:0] frame_length,
	output logic [3:0] byte_index,
	output logic [7:0] data_byte,
	output logic [2:0] channel_number,
	output logic       channel_in_range,
	output logic       last
);

	asfr_pkg::ctrl_cmd_t  cmd;
	asfr_pkg::dp_status_t status;

	asfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	asfr_datapath #(
		.MAX_DATA (MAX_DATA)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rx_byte          (rx_byte),
		.cmd              (cmd),
		.status           (status),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.message_id       (message_id),
		.frame_length     (frame_length),
		.byte_index       (byte_index),
		.data_byte        (data_byte),
		.channel_number   (channel_number),
		.channel_in_range (channel_in_range),
		.last             (last)
	);

endmodule
`default_nettype wire
